// ----- sv/amino_acid_kmer_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the amino acid k-mer encoder
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AMINO_ACID_KMER_ENCODER_MACROS_SVH
`define AMINO_ACID_KMER_ENCODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AAKE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aake assertion failed");

// antecedent implies consequent in the next cycle
`define AAKE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aake assertion failed");

`endif

// ----- sv/aake_pkg.sv -----
// ----------------------------------------------------------------------------
// aake_pkg
// Widths, constants and the residue lookup of the k-mer encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package aake_pkg;

	localparam int CODE_BITS     = 5;
	localparam int MAX_K_DEF     = 25;
	localparam int K_BITS        = 5;
	localparam int KEY_BITS      = 125;
	localparam int KEY_LOW_BITS  = 64;
	localparam int KEY_HIGH_BITS = 61;
	localparam int CHAR_BITS     = 8;
	localparam int PID_BITS      = 8;

	localparam logic [K_BITS-1:0]    K_RESET   = 5'd5;
	localparam logic [CHAR_BITS-1:0] DASH_CHAR = 8'h2D;

	// one accepted word as seen by the window unit
	typedef struct packed {
		logic                 advance;
		logic                 row_start;
		logic                 dash;
		logic                 hit;
		logic [CODE_BITS-1:0] code;
	} step_t;

	// fold case, then map to {hit, code}; hit low for anything outside the alphabet
	function automatic logic [CODE_BITS:0] code_of(input logic [CHAR_BITS-1:0] ch);
		logic [CHAR_BITS-1:0] up;
		logic [CODE_BITS:0]   res;
		up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
		case (up)
			8'h41: res = {1'b1, 5'd0};  // A
			8'h52: res = {1'b1, 5'd1};  // R
			8'h4E: res = {1'b1, 5'd2};  // N
			8'h44: res = {1'b1, 5'd3};  // D
			8'h43: res = {1'b1, 5'd4};  // C
			8'h51: res = {1'b1, 5'd5};  // Q
			8'h45: res = {1'b1, 5'd6};  // E
			8'h47: res = {1'b1, 5'd7};  // G
			8'h48: res = {1'b1, 5'd8};  // H
			8'h49: res = {1'b1, 5'd9};  // I
			8'h4C: res = {1'b1, 5'd10}; // L
			8'h4B: res = {1'b1, 5'd11}; // K
			8'h4D: res = {1'b1, 5'd12}; // M
			8'h46: res = {1'b1, 5'd13}; // F
			8'h50: res = {1'b1, 5'd14}; // P
			8'h53: res = {1'b1, 5'd15}; // S
			8'h54: res = {1'b1, 5'd16}; // T
			8'h57: res = {1'b1, 5'd17}; // W
			8'h59: res = {1'b1, 5'd18}; // Y
			8'h56: res = {1'b1, 5'd19}; // V
			8'h42: res = {1'b1, 5'd20}; // B
			8'h5A: res = {1'b1, 5'd21}; // Z
			8'h55: res = {1'b1, 5'd22}; // U
			8'h58: res = {1'b1, 5'd23}; // X
			8'h4F: res = {1'b1, 5'd24}; // O
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- sv/amino_acid_kmer_encoder.sv -----
// ----------------------------------------------------------------------------
// amino_acid_kmer_encoder: one character per cycle unless the output stalls, rolling k-mer keys of 5-bit codes
// From input word to key word: input register, then result register.
// Throughput one word per cycle while the result register is free or drained; the window updates once per word.
// Reset clears the window, the run count, both valid flags and sets k to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module amino_acid_kmer_encoder #(
	parameter int MAX_K = aake_pkg::MAX_K_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aake_pkg::K_BITS-1:0]         kmer_length,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [aake_pkg::CHAR_BITS-1:0]      amino_char,
	input  wire logic [aake_pkg::PID_BITS-1:0]       proteome_id,
	input  wire logic                                row_start,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [aake_pkg::KEY_LOW_BITS-1:0]        key_low,
	output logic [aake_pkg::KEY_HIGH_BITS-1:0]       key_high,
	output logic [aake_pkg::PID_BITS-1:0]            key_proteome
);

	logic [aake_pkg::K_BITS-1:0]        kmer_length_q, k_eff;
	logic                               valid_s1;
	logic [aake_pkg::CHAR_BITS-1:0]     char_s1;
	logic [aake_pkg::PID_BITS-1:0]      pid_s1;
	logic                               row_start_s1;
	logic [aake_pkg::CODE_BITS:0]       lookup;
	logic                               advance, emit, out_valid_q;
	logic [aake_pkg::KEY_LOW_BITS-1:0]  win_key_low, key_low_q;
	logic [aake_pkg::KEY_HIGH_BITS-1:0] win_key_high, key_high_q;
	logic [aake_pkg::PID_BITS-1:0]      key_proteome_q;
	aake_pkg::step_t                    step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= aake_pkg::K_RESET;
		end else if (cfg_valid) begin
			kmer_length_q <= kmer_length;
		end
	end

	// zero acts as one, clamp to MAX_K
	always_comb begin
		if (kmer_length_q == '0)
			k_eff = aake_pkg::K_BITS'(1);
		else if (kmer_length_q > aake_pkg::K_BITS'(MAX_K))
			k_eff = aake_pkg::K_BITS'(MAX_K);
		else
			k_eff = kmer_length_q;
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1      <= amino_char;
			pid_s1       <= proteome_id;
			row_start_s1 <= row_start;
		end
	end

	assign lookup = aake_pkg::code_of(char_s1);

	always_comb begin
		step.advance   = advance;
		step.row_start = row_start_s1;
		step.dash      = char_s1 == aake_pkg::DASH_CHAR;
		step.hit       = lookup[aake_pkg::CODE_BITS];
		step.code      = lookup[aake_pkg::CODE_BITS-1:0];
	end

	aake_window #(
		.MAX_K (MAX_K)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.k_eff    (k_eff),
		.emit     (emit),
		.key_low  (win_key_low),
		.key_high (win_key_high)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			key_low_q      <= win_key_low;
			key_high_q     <= win_key_high;
			key_proteome_q <= pid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign key_low      = key_low_q;
	assign key_high     = key_high_q;
	assign key_proteome = key_proteome_q;

endmodule

`default_nettype wire

// ----- sv/aake_window.sv -----
// ----------------------------------------------------------------------------
// aake_window
// Rolling window of residue codes, run counter and masked key generation.
// ----------------------------------------------------------------------------
`default_nettype none

module aake_window #(
	parameter int MAX_K = aake_pkg::MAX_K_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire aake_pkg::step_t                     step,
	input  wire logic [aake_pkg::K_BITS-1:0]         k_eff,
	output logic                                     emit,
	output logic [aake_pkg::KEY_LOW_BITS-1:0]        key_low,
	output logic [aake_pkg::KEY_HIGH_BITS-1:0]       key_high
);

	localparam int W        = MAX_K * aake_pkg::CODE_BITS;
	localparam int RUN_BITS = $clog2(MAX_K + 1);

	logic [W-1:0]                         win_q, win_d, base_win, win_shift, mask, key_w;
	logic [W+aake_pkg::CODE_BITS-1:0]     shift_ext;
	logic [RUN_BITS-1:0]                  run_q, run_d, base_run, run_inc;
	logic [aake_pkg::KEY_BITS-1:0]        key_full;

	always_comb begin
		base_win  = step.row_start ? '0 : win_q;
		base_run  = step.row_start ? '0 : run_q;
		shift_ext = {base_win, step.code};
		win_shift = shift_ext[W-1:0];
		// saturate at MAX_K
		run_inc   = (base_run < RUN_BITS'(MAX_K)) ? RUN_BITS'(base_run + 1'b1) : base_run;
		if (step.dash) begin
			win_d = base_win;
			run_d = base_run;
			emit  = 1'b0;
		end else if (!step.hit) begin
			win_d = '0;
			run_d = '0;
			emit  = 1'b0;
		end else begin
			win_d = win_shift;
			run_d = run_inc;
			emit  = aake_pkg::K_BITS'(run_inc) >= k_eff;
		end
	end

	// keep the newest k_eff residues
	always_comb begin
		for (int g = 0; g < MAX_K; g++) begin
			mask[g*aake_pkg::CODE_BITS +: aake_pkg::CODE_BITS] =
				{aake_pkg::CODE_BITS{aake_pkg::K_BITS'(g) < k_eff}};
		end
		key_w    = win_shift & mask;
		key_full = aake_pkg::KEY_BITS'(key_w);
	end

	assign key_low  = key_full[aake_pkg::KEY_LOW_BITS-1:0];
	assign key_high = key_full[aake_pkg::KEY_BITS-1:aake_pkg::KEY_LOW_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			run_q <= '0;
		end else if (step.advance) begin
			win_q <= win_d;
			run_q <= run_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/aake_checker.sv -----
// ----------------------------------------------------------------------------
// aake_checker
// Port-level checks on the k-mer encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "amino_acid_kmer_encoder_macros.svh"

module aake_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_ready,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [aake_pkg::KEY_LOW_BITS-1:0]   key_low,
	input wire logic [aake_pkg::KEY_HIGH_BITS-1:0]  key_high,
	input wire logic [aake_pkg::PID_BITS-1:0]       key_proteome
);

	// hold a stalled key word
	`AAKE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_low) && $stable(key_high) && $stable(key_proteome))

	// newest residue is always a real alphabet code
	`AAKE_ASSERT_SAME(a_last_code, out_valid, key_low[aake_pkg::CODE_BITS-1:0] <= 5'd24)

	// an empty result register never backs up the input
	`AAKE_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

	// register writes are never refused
	`AAKE_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind amino_acid_kmer_encoder aake_checker u_aake_checker (.*);

`default_nettype wire
